### src/csog_pkg.sv
// ---------------------------------------------------------------------------
// csog_pkg: shared types and codes for the control stream order guard
// Field widths, result/action/verdict codes and the front-to-back
// descriptor that carries all results of one request.
// ---------------------------------------------------------------------------
`default_nettype none

package csog_pkg;

  // Sequence handling: low SEQ_BITS of the 53-bit field are significant.
  localparam int SEQ_BITS    = 53;
  localparam int SEQ_FIELD_W = 53;
  localparam int SEQ_W       = (SEQ_BITS < SEQ_FIELD_W) ? SEQ_BITS : SEQ_FIELD_W;

  localparam int CMD_W  = 3;
  localparam int TAG_W  = 64;
  localparam int GEN_W  = 32;
  localparam int KIND_W = 2;
  localparam int ACT_W  = 2;
  localparam int VRD_W  = 3;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_ARM     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COMMAND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DISARM  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REVOKE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SWITCH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVENT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd3;

  // Event actions
  localparam logic [ACT_W-1:0] ACT_STOP = 2'd3;

  // Verdict codes
  localparam logic [VRD_W-1:0] VRD_OK         = 3'd0;
  localparam logic [VRD_W-1:0] VRD_DOWNSTREAM = 3'd1;
  localparam logic [VRD_W-1:0] VRD_BLOCKED    = 3'd2;
  localparam logic [VRD_W-1:0] VRD_NOT_ARMED  = 3'd3;
  localparam logic [VRD_W-1:0] VRD_MISMATCH   = 3'd4;
  localparam logic [VRD_W-1:0] VRD_SEQUENCE   = 3'd5;
  localparam logic [VRD_W-1:0] VRD_SWITCH_REJ = 3'd6;

  // Everything the back end needs to emit the results of one request.
  typedef struct packed {
    logic              stop_en;
    logic [KIND_W-1:0] stop_kind;
    logic [TAG_W-1:0]  stop_tag;
    logic [SEQ_W-1:0]  stop_seq;
    logic              evt_en;
    logic              vrd_en;
    logic [VRD_W-1:0]  vrd_code;
    logic [ACT_W-1:0]  action;
    logic [TAG_W-1:0]  tag;
    logic [SEQ_W-1:0]  seq;
  } desc_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

### src/control_stream_order_guard.sv
// ---------------------------------------------------------------------------
// control_stream_order_guard: order guard for a parsed motion control stream
// Authority check, arm/command/disarm/stop order check and stream switch
// handling; up to three results per request, delivered as a queue.
// ---------------------------------------------------------------------------
// Path: queue entry, back end's current descriptor register, output slot.
// Throughput: one request accepted per cycle while the two-entry descriptor
//   queue has room; the output slot drains one result per cycle unless it stalls
//   on out_pop, so the sustained request rate follows each result count.
// Reset: synchronous, active low; no stream armed, stream state zero, queue and
//   output slot empty.
`default_nettype none

module control_stream_order_guard (
  input  wire                              clk,
  input  wire                              rst_n,
  // request channel
  input  wire                              in_push,
  output logic                             in_full,
  input  wire [csog_pkg::CMD_W-1:0]        in_command,
  input  wire [csog_pkg::TAG_W-1:0]        in_stream_tag,
  input  wire [csog_pkg::SEQ_FIELD_W-1:0]  in_seq_number,
  input  wire                              in_lan_permitted,
  input  wire [csog_pkg::GEN_W-1:0]        in_authority_generation,
  input  wire                              in_stop_will_accept,
  input  wire                              in_event_will_accept,
  // result channel
  output logic                             out_empty,
  input  wire                              out_pop,
  output logic [csog_pkg::KIND_W-1:0]      out_result_kind,
  output logic [csog_pkg::ACT_W-1:0]       out_event_action,
  output logic [csog_pkg::TAG_W-1:0]       out_event_stream,
  output logic [csog_pkg::SEQ_FIELD_W-1:0] out_event_sequence,
  output logic [csog_pkg::VRD_W-1:0]       out_verdict_code,
  output logic                             out_last_of_run
);

  // Front: classifies the request against the live stream state and
  // commits the state in the accept cycle, so the next request sees it.
  // Each request that yields results becomes one descriptor holding all of them.
  logic              q_push;
  csog_pkg::desc_t   q_desc;

  // Queue between front and back; full is the request backpressure.
  csog_pkg::desc_t   head_desc;
  csog_pkg::q_stat_t q_stat;
  logic              q_pop;

  assign in_full = q_stat.full;

  csog_front u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_push                 (in_push),
    .q_full                  (q_stat.full),
    .in_command              (in_command),
    .in_stream_tag           (in_stream_tag),
    .in_seq_number           (in_seq_number),
    .in_lan_permitted        (in_lan_permitted),
    .in_authority_generation (in_authority_generation),
    .in_stop_will_accept     (in_stop_will_accept),
    .in_event_will_accept    (in_event_will_accept),
    .q_push                  (q_push),
    .q_desc                  (q_desc)
  );

  csog_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .stat      (q_stat)
  );

  // Back: emits stop, forwarded event and verdict in that order, one per
  // cycle, through a registered output slot that may stall on out_pop.
  csog_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_desc          (head_desc),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_result_kind    (out_result_kind),
    .out_event_action   (out_event_action),
    .out_event_stream   (out_event_stream),
    .out_event_sequence (out_event_sequence),
    .out_verdict_code   (out_verdict_code),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

`default_nettype wire

### src/csog_front.sv
// ---------------------------------------------------------------------------
// csog_front: authority check, order check and stream state
// Classifies one request per cycle while the queue has room, commits the
// stream state and hands a result descriptor to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module csog_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_push,
  input  wire                           q_full,
  input  wire [csog_pkg::CMD_W-1:0]     in_command,
  input  wire [csog_pkg::TAG_W-1:0]     in_stream_tag,
  input  wire [csog_pkg::SEQ_FIELD_W-1:0] in_seq_number,
  input  wire                           in_lan_permitted,
  input  wire [csog_pkg::GEN_W-1:0]     in_authority_generation,
  input  wire                           in_stop_will_accept,
  input  wire                           in_event_will_accept,
  output logic                          q_push,
  output csog_pkg::desc_t               q_desc
);

  logic                         live_r, live_nxt;
  logic [csog_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic [csog_pkg::SEQ_W-1:0]   seq_r, seq_nxt;
  logic [csog_pkg::GEN_W-1:0]   gen_r, gen_nxt;

  logic                         accept;
  logic                         revoke;
  logic                         live1;
  logic                         is_req;
  logic                         is_arm;
  logic                         is_cmd;
  logic                         is_end;
  logic                         switch_stop;
  logic                         forward;
  logic [csog_pkg::VRD_W-1:0]   code;
  logic [csog_pkg::SEQ_W-1:0]   seq_in;
  logic                         tag_eq;
  logic                         seq_old;

  assign seq_in = in_seq_number[csog_pkg::SEQ_W-1:0];
  assign accept = in_push && !q_full;
  assign revoke = live_r && (!in_lan_permitted || (gen_r != in_authority_generation));
  assign live1  = live_r && !revoke;
  assign is_req = (in_command[2] == 1'b0);
  assign is_arm = (in_command == csog_pkg::CMD_ARM);
  assign is_cmd = (in_command == csog_pkg::CMD_COMMAND);
  assign is_end = (in_command == csog_pkg::CMD_DISARM) || (in_command == csog_pkg::CMD_STOP);
  assign tag_eq  = (in_stream_tag == tag_r);
  assign seq_old = (seq_in <= seq_r);

  // Order check; state seen here is after the authority check
  always_comb begin
    switch_stop = 1'b0;
    forward     = 1'b0;
    code        = csog_pkg::VRD_OK;
    priority if ((is_arm || is_cmd) && !in_lan_permitted) begin
      code = csog_pkg::VRD_BLOCKED;
    end else if (is_cmd && !live1) begin
      code = csog_pkg::VRD_NOT_ARMED;
    end else if (is_cmd && !tag_eq) begin
      code = csog_pkg::VRD_MISMATCH;
    end else if ((is_cmd || (is_arm && live1 && tag_eq)) && seq_old) begin
      code = csog_pkg::VRD_SEQUENCE;
    end else if (is_arm && live1 && !tag_eq && !in_stop_will_accept) begin
      switch_stop = 1'b1;
      code        = csog_pkg::VRD_SWITCH_REJ;
    end else begin
      switch_stop = is_arm && live1 && !tag_eq;
      forward     = 1'b1;
      code        = in_event_will_accept ? csog_pkg::VRD_OK : csog_pkg::VRD_DOWNSTREAM;
    end
  end

  // Stream state commit
  always_comb begin
    live_nxt = live_r;
    tag_nxt  = tag_r;
    seq_nxt  = seq_r;
    gen_nxt  = gen_r;
    if (accept) begin
      if (revoke || (is_req && switch_stop) || (is_req && forward && is_end)) begin
        live_nxt = 1'b0;
        tag_nxt  = '0;
        seq_nxt  = '0;
        gen_nxt  = '0;
      end
      if (is_req && forward && in_event_will_accept) begin
        if (is_arm) begin
          live_nxt = 1'b1;
          tag_nxt  = in_stream_tag;
          gen_nxt  = in_authority_generation;
          seq_nxt  = seq_in;
        end else if (is_cmd) begin
          seq_nxt  = seq_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      tag_r  <= '0;
      seq_r  <= '0;
      gen_r  <= '0;
    end else begin
      live_r <= live_nxt;
      tag_r  <= tag_nxt;
      seq_r  <= seq_nxt;
      gen_r  <= gen_nxt;
    end
  end

  // Revoke and switch stops exclude each other; both carry the live stream
  always_comb begin
    q_desc.stop_en   = revoke || (is_req && switch_stop);
    q_desc.stop_kind = revoke ? csog_pkg::KIND_REVOKE : csog_pkg::KIND_SWITCH;
    q_desc.stop_tag  = tag_r;
    q_desc.stop_seq  = seq_r;
    q_desc.evt_en    = is_req && forward;
    q_desc.vrd_en    = is_req;
    q_desc.vrd_code  = code;
    q_desc.action    = in_command[csog_pkg::ACT_W-1:0];
    q_desc.tag       = in_stream_tag;
    q_desc.seq       = seq_in;
  end

  // A poll with no revocation yields nothing and is not queued
  assign q_push = accept && (revoke || is_req);

endmodule

`default_nettype wire

### src/csog_queue.sv
// ---------------------------------------------------------------------------
// csog_queue: two-entry descriptor queue
// Decouples request classification from result sequencing.
// ---------------------------------------------------------------------------
`default_nettype none

module csog_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire csog_pkg::desc_t push_desc,
  input  wire                pop,
  output csog_pkg::desc_t    head_desc,
  output csog_pkg::q_stat_t  stat
);

  csog_pkg::desc_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

### src/csog_back.sv
// ---------------------------------------------------------------------------
// csog_back: result sequencer and output register
// Walks the results of one descriptor, one per cycle unless the output slot stalls on out_pop, into the slot.
// ---------------------------------------------------------------------------
`default_nettype none

module csog_back (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire csog_pkg::desc_t            head_desc,
  input  wire csog_pkg::q_stat_t          q_stat,
  output logic                            q_pop,
  input  wire                             out_pop,
  output logic                            out_empty,
  output logic [csog_pkg::KIND_W-1:0]     out_result_kind,
  output logic [csog_pkg::ACT_W-1:0]      out_event_action,
  output logic [csog_pkg::TAG_W-1:0]      out_event_stream,
  output logic [csog_pkg::SEQ_FIELD_W-1:0] out_event_sequence,
  output logic [csog_pkg::VRD_W-1:0]      out_verdict_code,
  output logic                            out_last_of_run
);

  // rem bits: 0 stop, 1 forwarded event, 2 verdict
  csog_pkg::desc_t cur_r, cur_nxt;
  logic [2:0]      rem_r, rem_nxt;
  logic            ov_r, ov_nxt;

  logic [csog_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [csog_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic [csog_pkg::TAG_W-1:0]  strm_r, strm_nxt;
  logic [csog_pkg::SEQ_W-1:0]  seq_r, seq_nxt;
  logic [csog_pkg::VRD_W-1:0]  vrd_r, vrd_nxt;
  logic                        last_r, last_nxt;

  logic       take;
  logic [2:0] sel;
  logic [2:0] rem_after;
  logic       load_cur;

  assign take      = (rem_r != 3'b000) && (!ov_r || out_pop);
  assign sel       = rem_r & (~rem_r + 3'b001);
  assign rem_after = rem_r & ~sel;
  assign load_cur  = (rem_r == 3'b000) || (take && (rem_after == 3'b000));
  assign q_pop     = load_cur && !q_stat.empty;

  always_comb begin
    cur_nxt = cur_r;
    rem_nxt = take ? rem_after : rem_r;
    if (q_pop) begin
      cur_nxt = head_desc;
      rem_nxt = {head_desc.vrd_en, head_desc.evt_en, head_desc.stop_en};
    end
  end

  always_comb begin
    ov_nxt   = ov_r && !out_pop;
    kind_nxt = kind_r;
    act_nxt  = act_r;
    strm_nxt = strm_r;
    seq_nxt  = seq_r;
    vrd_nxt  = vrd_r;
    last_nxt = last_r;
    if (take) begin
      ov_nxt   = 1'b1;
      last_nxt = (rem_after == 3'b000);
      unique case (1'b1)
        sel[0]: begin
          kind_nxt = cur_r.stop_kind;
          act_nxt  = csog_pkg::ACT_STOP;
          strm_nxt = cur_r.stop_tag;
          seq_nxt  = cur_r.stop_seq;
          vrd_nxt  = csog_pkg::VRD_OK;
        end
        sel[1]: begin
          kind_nxt = csog_pkg::KIND_EVENT;
          act_nxt  = cur_r.action;
          strm_nxt = cur_r.tag;
          seq_nxt  = cur_r.seq;
          vrd_nxt  = csog_pkg::VRD_OK;
        end
        default: begin
          kind_nxt = csog_pkg::KIND_VERDICT;
          act_nxt  = cur_r.action;
          strm_nxt = cur_r.tag;
          seq_nxt  = cur_r.seq;
          vrd_nxt  = cur_r.vrd_code;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'b000;
      ov_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    kind_r <= kind_nxt;
    act_r  <= act_nxt;
    strm_r <= strm_nxt;
    seq_r  <= seq_nxt;
    vrd_r  <= vrd_nxt;
    last_r <= last_nxt;
  end

  assign out_empty          = !ov_r;
  assign out_result_kind    = kind_r;
  assign out_event_action   = act_r;
  assign out_event_stream   = strm_r;
  assign out_event_sequence = csog_pkg::SEQ_FIELD_W'(seq_r);
  assign out_verdict_code   = vrd_r;
  assign out_last_of_run    = last_r;

`ifndef SYNTHESIS
  // A stalled slot keeps the pending results of the current request
  a_rem_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 3'b000) && ov_r && !out_pop |=> (rem_r == $past(rem_r)))
    else $error("pending results changed during stall");

  // Finishing the walk of a descriptor marks the end of its run
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    take && (rem_after == 3'b000) |=> (ov_r && last_r))
    else $error("run end not flagged");

  // New descriptor only when the current one is spent
  a_pop_spent: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> ((rem_r == 3'b000) || (take && $onehot(rem_r))))
    else $error("descriptor popped while results pending");
`endif

endmodule

`default_nettype wire
